// File: src/crrm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm_pkg - shared types for the cascaded range remapper
// Transaction payloads, table entry layout and fixed widths.
// ---------------------------------------------------------------------------
package crrm_pkg;

   // value width is fixed by the payload fields
   localparam int VALUE_BITS = 32;
   localparam int CFG_BITS   = 4;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd7;

   // front/back transaction queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_XLATE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  opcode;
      logic [2:0]              stage_index;
      logic [5:0]              slot_index;
      logic [VALUE_BITS-1:0]   dest_start;
      logic [VALUE_BITS-1:0]   source_start;
      logic [VALUE_BITS-1:0]   range_length;
      logic                    entry_valid;
      logic [VALUE_BITS-1:0]   map_value;
      logic                    last_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]   mapped_value;
      logic [VALUE_BITS-1:0]   running_min;
      logic                    batch_done;
   } rsp_type;

   // one table slot as stored in RAM
   typedef struct packed {
      logic                    ok;
      logic [VALUE_BITS-1:0]   dest;
      logic [VALUE_BITS-1:0]   src;
      logic [VALUE_BITS-1:0]   len;
   } entry_type;

endpackage

// File: src/crrm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module crrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/crrm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm_front - request intake and transaction queue
// Accepts requests, drops loads that address no slot, and queues the rest
// in order for the back end.
// ---------------------------------------------------------------------------
module crrm_front #(
   parameter int STAGES  = 8,
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  crrm_pkg::req_type req_data,
   input  logic             clearing,
   output logic             head_valid,
   output crrm_pkg::req_type head,
   input  logic             head_pop
);
   import crrm_pkg::*;

   req_type             q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                in_range;
   logic                accept;
   logic                push;

   // classify: a load outside the table is accepted and dropped
   assign in_range = (32'(req_data.stage_index) < STAGES) &&
                     (32'(req_data.slot_index) < ENTRIES);
   assign req_stall = (count_ff == QCNT_W'(QDEPTH)) || clearing;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && ((req_data.opcode == OP_XLATE) || in_range);

   assign head_valid = (count_ff != '0);
   assign head       = q_mem[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count above depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (count_ff != '0))
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push lost");
`endif

endmodule

// File: src/crrm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crrm_back - table store and translation engine
// Holds one small RAM per slot, indexed by stage. A translation walks the
// stages one per cycle, comparing all slots of a stage in parallel, then
// folds the result into the batch minimum and the output register.
// ---------------------------------------------------------------------------
module crrm_back #(
   parameter int STAGES  = 8,
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  crrm_pkg::req_type             head,
   output logic                          head_pop,
   output logic                          clearing,
   input  logic [crrm_pkg::CFG_BITS-1:0] stages_in_use,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output crrm_pkg::rsp_type             rsp_data
);
   import crrm_pkg::*;

   localparam int STAGE_AW = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int CNT_W    = $clog2(STAGES + 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [STAGE_AW-1:0]    stage_ff, stage_in;
   logic [STAGE_AW-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]       num_ff, num_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic                   last_ff, last_in;
   logic [VALUE_BITS-1:0]  min_ff, min_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [ENTRIES-1:0]     wr_en;
   logic [STAGE_AW-1:0]    wr_addr;
   entry_type              wr_data;
   logic [STAGE_AW-1:0]    rd_addr;
   entry_type              rd_row [ENTRIES];

   logic [CNT_W-1:0]       num_cfg;
   logic [ENTRIES-1:0]     hit;
   logic [ENTRIES-1:0]     first;
   logic [VALUE_BITS-1:0]  sel_src;
   logic [VALUE_BITS-1:0]  sel_dst;
   logic [VALUE_BITS-1:0]  stage_out;
   logic [VALUE_BITS-1:0]  min_cand;
   logic                   last_stage;

   // one RAM per slot, addressed by stage
   for (genvar k = 0; k < ENTRIES; k++) begin : g_slot
      crrm_ram #(
         .WIDTH ($bits(entry_type)),
         .DEPTH (STAGES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[k]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_addr (rd_addr),
         .rd_data (rd_row[k])
      );
   end

   // stage count, clipped to the table depth
   assign num_cfg = (32'(stages_in_use) > STAGES) ? CNT_W'(STAGES)
                                                  : CNT_W'(stages_in_use);

   // window test for every slot of the current stage (33-bit end)
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         hit[k] = rd_row[k].ok &&
                  ({1'b0, value_ff} >= {1'b0, rd_row[k].src}) &&
                  ({1'b0, value_ff} < ({1'b0, rd_row[k].src} + {1'b0, rd_row[k].len}));
      end
   end

   // lowest hitting slot wins
   assign first = hit & (~hit + ENTRIES'(1));

   always_comb begin
      sel_src = '0;
      sel_dst = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         sel_src = sel_src | ({VALUE_BITS{first[k]}} & rd_row[k].src);
         sel_dst = sel_dst | ({VALUE_BITS{first[k]}} & rd_row[k].dest);
      end
   end

   assign stage_out  = (|hit) ? (value_ff - sel_src + sel_dst) : value_ff;
   assign last_stage = ((CNT_W'(stage_ff) + CNT_W'(1)) == num_ff);
   assign min_cand   = (value_ff < min_ff) ? value_ff : min_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      clr_in       = clr_ff;
      num_in       = num_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      wr_en        = '0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_addr      = '0;
      case (state_ff)
         ST_CLEAR: begin
            // invalidate one stage row across all slots per cycle
            wr_en = '1;
            if (clr_ff == STAGE_AW'(STAGES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head.opcode == OP_LOAD) begin
                  wr_en        = ENTRIES'(1) << head.slot_index;
                  wr_addr      = STAGE_AW'(head.stage_index);
                  wr_data.ok   = head.entry_valid;
                  wr_data.dest = head.dest_start;
                  wr_data.src  = head.source_start;
                  wr_data.len  = head.range_length;
               end else begin
                  value_in = head.map_value;
                  last_in  = head.last_value;
                  num_in   = num_cfg;
                  stage_in = '0;
                  state_in = (num_cfg == '0) ? ST_FINISH : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            value_in = stage_out;
            if (last_stage) begin
               state_in = ST_FINISH;
            end else begin
               stage_in = stage_ff + 1'b1;
               rd_addr  = stage_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.mapped_value = value_ff;
               rsp_in.running_min  = min_cand;
               rsp_in.batch_done   = last_ff;
               min_in   = last_ff ? '1 : min_cand;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stage_ff <= stage_in;
      num_ff   <= num_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !head_pop)
      else $error("queue popped during clearing pass");
   a_stage_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (CNT_W'(stage_ff) < num_ff))
      else $error("stage walk past stage count");
   a_min_le_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.running_min <= rsp_ff.mapped_value))
      else $error("running minimum above mapped value");
   a_one_hit_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> $onehot0(first))
      else $error("more than one slot selected");
`endif

endmodule

// File: src/cascaded_range_remap_min.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cascaded_range_remap_min - cascaded range-map translation with batch minimum
// Loads range tables per stage and translates values through them, returning
// each mapped value and the running minimum of its batch.
// ---------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_valid/req_stall  req_type (load or translate)
//  rsp_     out  rsp_valid/rsp_stall  rsp_type (one per translate)
//  csr_     in   csr_valid/csr_ready  stages_in_use, 4 bits
//
//  A translate passes through the back end as a queue pop, a stage walk over
//  min(stages_in_use, STAGES) stages of parallel slot compares and an output
//  fold; a load is done at the pop. The stage walk reads one stage row of all
//  slot RAMs per cycle. After reset a clearing pass invalidates all slots;
//  requests stall meanwhile, the csr port stays open. A four-entry queue lets
//  intake continue while the back end works or the response is stalled.
// ---------------------------------------------------------------------------
module cascaded_range_remap_min #(
   parameter int STAGES  = 8,
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  crrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output crrm_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [crrm_pkg::CFG_BITS-1:0] csr_wdata
);
   import crrm_pkg::*;

   logic [CFG_BITS-1:0] stages_ff;
   logic                head_valid;
   req_type             head;
   logic                head_pop;
   logic                clearing;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stages_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         stages_ff <= csr_wdata;
      end
   end

   crrm_front #(
      .STAGES  (STAGES),
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .clearing   (clearing),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   crrm_back #(
      .STAGES  (STAGES),
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .head_pop      (head_pop),
      .clearing      (clearing),
      .stages_in_use (stages_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

// File: dv/tb_cascaded_range_remap_min.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cascaded_range_remap_min - self-checking bench for the range remapper
// Loads range tables and translates values through the stage cascade, while
// both channels idle at random. Each result is checked field by field against
// a local model of the tables and the batch minimum. The stage count changes
// between phases, each time with the block drained.
// ---------------------------------------------------------------------------
module tb_cascaded_range_remap_min;
   import crrm_pkg::*;

   localparam int STAGES       = 8;
   localparam int ENTRIES      = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HINT_DEPTH   = 48;
   localparam int PHASE_ITEMS  = 130;

   // window of a loaded slot, kept so translate values land in or near it
   typedef struct {
      logic [2:0]            stage;
      logic [VALUE_BITS-1:0] src;
      logic [VALUE_BITS-1:0] len;
      logic [VALUE_BITS-1:0] dst;
   } window_hint_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   // model of the block
   logic [VALUE_BITS-1:0] slot_dest [STAGES][ENTRIES];
   logic [VALUE_BITS-1:0] slot_src  [STAGES][ENTRIES];
   logic [VALUE_BITS-1:0] slot_len  [STAGES][ENTRIES];
   logic                  slot_ok   [STAGES][ENTRIES];
   logic [VALUE_BITS-1:0] batch_low;
   logic [CFG_BITS-1:0]   stages_cfg;

   req_type         req_backlog [$];
   rsp_type         predicted_rsps [$];
   window_hint_type window_hints [$];

   logic calm_mode = 1'b0;
   int   accept_count  = 0;
   int   accept_seen   = 0;
   int   cycle_count   = 0;
   int   error_count   = 0;
   int   load_count    = 0;
   int   xlate_count   = 0;
   int   checked_count = 0;
   int   batch_count   = 0;
   int   cfg_writes    = 0;

   cascaded_range_remap_min #(
      .STAGES  (STAGES),
      .ENTRIES (ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_cascaded_range_remap_min: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // walk the stages in use; first valid slot whose window holds the value wins
   function automatic logic [VALUE_BITS-1:0] remap_value(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS:0]   window_end;
      logic                  hit;
      int                    n;
      v = value;
      n = (stages_cfg > STAGES) ? STAGES : int'(stages_cfg);
      for (int s = 0; s < n; s++) begin
         hit = 1'b0;
         for (int k = 0; k < ENTRIES; k++) begin
            window_end = {1'b0, slot_src[s][k]} + {1'b0, slot_len[s][k]};
            if (!hit && slot_ok[s][k] && v >= slot_src[s][k] && {1'b0, v} < window_end) begin
               v   = v - slot_src[s][k] + slot_dest[s][k];
               hit = 1'b1;
            end
         end
      end
      return v;
   endfunction

   // update the table model or queue the result of a translate
   task automatic apply_transaction(input req_type r);
      rsp_type res;
      if (r.opcode == OP_LOAD) begin
         slot_dest[r.stage_index][r.slot_index] = r.dest_start;
         slot_src[r.stage_index][r.slot_index]  = r.source_start;
         slot_len[r.stage_index][r.slot_index]  = r.range_length;
         slot_ok[r.stage_index][r.slot_index]   = r.entry_valid;
         load_count++;
      end else begin
         res.mapped_value = remap_value(r.map_value);
         if (res.mapped_value < batch_low) begin
            batch_low = res.mapped_value;
         end
         res.running_min = batch_low;
         res.batch_done  = r.last_value;
         if (r.last_value) begin
            batch_low = '1;
         end
         predicted_rsps = {predicted_rsps, res};
         xlate_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsps.size() == 0) begin
               $error("result with nothing pending: mapped_value %h running_min %h batch_done %b",
                      rsp_data.mapped_value, rsp_data.running_min, rsp_data.batch_done);
               error_count++;
            end else begin
               want = predicted_rsps.pop_front();
               checked_count++;
               if (want.batch_done) begin
                  batch_count++;
               end
               if (rsp_data.mapped_value !== want.mapped_value) begin
                  $error("mapped_value: expected %h, actual %h",
                         want.mapped_value, rsp_data.mapped_value);
                  error_count++;
               end
               if (rsp_data.running_min !== want.running_min) begin
                  $error("running_min: expected %h, actual %h",
                         want.running_min, rsp_data.running_min);
                  error_count++;
               end
               if (rsp_data.batch_done !== want.batch_done) begin
                  $error("batch_done: expected %b, actual %b",
                         want.batch_done, rsp_data.batch_done);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_transaction(req_data);
            accept_count++;
         end
      end
   end

   // ------------------------------------------------------------------
   // driver: change inputs at the falling edge
   // ------------------------------------------------------------------
   function automatic logic idle_roll();
      return !calm_mode && ($urandom_range(99) < 34);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // a stalled transaction holds; otherwise move on or idle
         if (!req_valid || (accept_count != accept_seen)) begin
            if (req_backlog.size() != 0 && !idle_roll()) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         accept_seen = accept_count;
         rsp_stall <= idle_roll();
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_type noise_request();
      req_type r;
      r.opcode       = op_type'($urandom_range(1));
      r.stage_index  = 3'($urandom);
      r.slot_index   = 6'($urandom);
      r.dest_start   = $urandom;
      r.source_start = $urandom;
      r.range_length = $urandom;
      r.entry_valid  = 1'($urandom);
      r.map_value    = $urandom;
      r.last_value   = 1'($urandom);
      return r;
   endfunction

   task automatic push_load(input logic [2:0] stage, input logic [5:0] slot,
                            input logic [VALUE_BITS-1:0] dst, input logic [VALUE_BITS-1:0] src,
                            input logic [VALUE_BITS-1:0] len, input logic ok);
      req_type r;
      r              = '1;
      r.opcode       = OP_LOAD;
      r.stage_index  = stage;
      r.slot_index   = slot;
      r.dest_start   = dst;
      r.source_start = src;
      r.range_length = len;
      r.entry_valid  = ok;
      req_backlog    = {req_backlog, r};
   endtask

   task automatic push_translate(input logic [VALUE_BITS-1:0] value, input logic last);
      req_type r;
      r            = '1;
      r.opcode     = OP_XLATE;
      r.map_value  = value;
      r.last_value = last;
      req_backlog  = {req_backlog, r};
   endtask

   // random load; often chained onto the output window of an earlier stage
   function automatic req_type random_load();
      req_type         r;
      window_hint_type h;
      logic            chained;
      r         = noise_request();
      r.opcode  = OP_LOAD;
      chained   = 1'b0;
      r.slot_index = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(7));
      case ($urandom_range(9))
         0:       r.range_length = '0;
         1:       r.range_length = '1;
         2:       r.range_length = $urandom;
         default: r.range_length = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(7))
         0:       r.source_start = 32'hFFFF_F000 | $urandom_range(4095);
         1:       r.source_start = $urandom_range(4095);
         default: r.source_start = $urandom;
      endcase
      if ($urandom_range(7) == 0) begin
         r.dest_start = 32'hFFFF_FF00 | $urandom_range(255);
      end
      if (window_hints.size() != 0 && $urandom_range(1) == 0) begin
         h = window_hints[$urandom_range(window_hints.size() - 1)];
         if (h.stage != 3'd7) begin
            chained        = 1'b1;
            r.stage_index  = h.stage + 3'd1;
            r.source_start = h.dst - $urandom_range(32);
            r.range_length = $urandom_range(64, 8192);
         end
      end
      if (!chained) begin
         r.stage_index = 3'($urandom_range(7));
      end
      r.entry_valid = ($urandom_range(7) != 0);
      if (r.entry_valid && r.range_length != 0) begin
         h.stage = r.stage_index;
         h.src   = r.source_start;
         h.len   = r.range_length;
         h.dst   = r.dest_start;
         window_hints = {window_hints, h};
         if (window_hints.size() > HINT_DEPTH) begin
            void'(window_hints.pop_front());
         end
      end
      return r;
   endfunction

   // translate value: window edges, inside, outside, extremes or anything
   function automatic logic [VALUE_BITS-1:0] pick_value();
      window_hint_type       h;
      logic [VALUE_BITS-1:0] v;
      v = $urandom;
      if (window_hints.size() != 0 && $urandom_range(99) < 70) begin
         h = window_hints[$urandom_range(window_hints.size() - 1)];
         case ($urandom_range(4))
            0:       v = h.src;
            1:       v = h.src + h.len - 1;
            2:       v = h.src + h.len;
            3:       v = h.src - 1;
            default: v = h.src + ($urandom % h.len);
         endcase
      end else if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       v = '0;
            1:       v = '1;
            2:       v = 32'h8000_0000;
            default: v = 32'h7FFF_FFFF;
         endcase
      end
      return v;
   endfunction

   task automatic fill_random_phase(input int count);
      req_type r;
      int      opening_loads;
      opening_loads = $urandom_range(8, 24);
      for (int i = 0; i < count; i++) begin
         if (i < opening_loads || $urandom_range(99) < 15) begin
            r = random_load();
         end else begin
            r            = noise_request();
            r.opcode     = OP_XLATE;
            r.map_value  = pick_value();
            r.last_value = ($urandom_range(7) == 0);
         end
         req_backlog = {req_backlog, r};
      end
   endtask

   // sender holds off until every result is back and trailing loads are done
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || predicted_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_stages(input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      stages_cfg = value;
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= CFG_BITS'($urandom);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [CFG_BITS-1:0] stage_plan [8];
      stage_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd7};

      for (int s = 0; s < STAGES; s++) begin
         for (int k = 0; k < ENTRIES; k++) begin
            slot_dest[s][k] = '0;
            slot_src[s][k]  = '0;
            slot_len[s][k]  = '0;
            slot_ok[s][k]   = 1'b0;
         end
      end
      batch_low  = '1;
      stages_cfg = CFG_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty tables, priority, wrap, zero length, cleared slot
      push_translate(32'h0000_0000, 1'b0);
      push_translate(32'hFFFF_FFFF, 1'b1);
      push_load(3'd0, 6'd0, 32'hFFFF_FFFA, 32'd100, 32'd10, 1'b1);
      push_load(3'd0, 6'd1, 32'd1000, 32'd100, 32'd50, 1'b1);
      push_load(3'd0, 6'd2, 32'd0, 32'd50, 32'd0, 1'b1);
      push_translate(32'd105, 1'b0);
      push_translate(32'd109, 1'b0);
      push_translate(32'd110, 1'b0);
      push_translate(32'd99, 1'b0);
      push_translate(32'd50, 1'b0);
      // window end past 32 bits, highest slot
      push_load(3'd1, 6'd63, 32'd5, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
      push_translate(32'hFFFF_FFF0, 1'b0);
      push_load(3'd0, 6'd0, 32'hFFFF_FFFA, 32'd100, 32'd10, 1'b0);
      push_translate(32'd105, 1'b1);
      push_load(3'd2, 6'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b1);
      push_load(3'd7, 6'd5, 32'd7, 32'd0, 32'hFFFF_FFFF, 1'b1);
      push_translate(32'd0, 1'b0);
      push_translate(32'd1, 1'b0);
      wait_drained();
      // last stage now in use
      write_stages(4'd8);
      push_translate(32'd1, 1'b0);
      push_translate(32'd0, 1'b1);

      // random phases, one stage count each; phase 3 runs without idling
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         write_stages(stage_plan[p]);
         calm_mode = (p == 3);
         fill_random_phase(PHASE_ITEMS);
      end
      wait_drained();

      $display("%0d transactions in (%0d loads, %0d translates), %0d results checked",
               load_count + xlate_count, load_count, xlate_count, checked_count);
      $display("%0d batches closed over %0d stage-count settings, 0 through 15",
               batch_count, cfg_writes);
      if (error_count == 0) begin
         $display("tb_cascaded_range_remap_min: clean");
      end else begin
         $display("tb_cascaded_range_remap_min: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/crrm_pkg.sv
src/crrm_ram.sv
src/crrm_front.sv
src/crrm_back.sv
src/cascaded_range_remap_min.sv
dv/tb_cascaded_range_remap_min.sv
